// File: hw/rtl/smfd_pkg.sv
// Package: constants, types and constant tables of the modulated feedback delay.
package smfd_pkg;

    localparam int ADDR_W    = 17;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int SMP_W     = 16;
    localparam int MUL_W     = 33;
    localparam int SINE_N    = 1024;
    localparam int SHAPE_N   = 1024;
    localparam int FB_LIMIT  = 62259;
    localparam int UNITY     = 65536;
    // ceil(2^35 / 25), reciprocal for the divide by 25 of the delay scaling
    localparam logic [30:0] RECIP_25 = 31'd1374389535;

    localparam logic [2:0] CFG_WET  = 3'd0;
    localparam logic [2:0] CFG_FB   = 3'd1;
    localparam logic [2:0] CFG_OCT  = 3'd2;
    localparam logic [2:0] CFG_BASE = 3'd3;
    localparam logic [2:0] CFG_STEP = 3'd4;

    typedef logic signed [17:0] t_sine_rom [SINE_N];
    typedef logic signed [SMP_W-1:0] t_shape_rom [SHAPE_N+1];

    function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = (r << 1) | ((n >> i) & 64'd1);
            if (r >= d) begin
                r = r - d;
                q = q | (64'd1 << i);
            end
        end
        return q;
    endfunction

    function automatic longint sine_val(longint unsigned k);
        longint unsigned quad;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned inner;
        longint unsigned mid;
        longint unsigned s;
        quad = (k >> 8) & 64'd3;
        t = (k & 64'd255) << 8;
        if (quad[0]) t = 64'd65536 - t;
        t2 = (t * t) >> 16;
        inner = 64'd42184 - ((t2 * 64'd4776) >> 16);
        mid = 64'd102944 - ((t2 * inner) >> 16);
        s = (t * mid) >> 16;
        if (s > 64'd65536) s = 64'd65536;
        return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    function automatic t_sine_rom build_sine();
        t_sine_rom rom;
        for (int i = 0; i < SINE_N; i++) begin
            rom[i] = 18'(sine_val(longint'(i)));
        end
        return rom;
    endfunction

    function automatic longint unsigned tanh_q16(longint unsigned y);
        longint unsigned y2;
        longint unsigned y4;
        longint unsigned y6;
        longint unsigned n;
        longint unsigned d;
        y2 = (y * y) >> 16;
        y4 = (y2 * y2) >> 16;
        y6 = (y4 * y2) >> 16;
        n = (64'd135135 << 16) + 64'd17325 * y2 + 64'd378 * y4 + y6;
        d = (64'd135135 << 16) + 64'd62370 * y2 + 64'd3150 * y4 + 64'd28 * y6;
        return udiv(n * y + (d >> 1), d);
    endfunction

    function automatic longint shape_val(longint unsigned k);
        longint x;
        longint unsigned m;
        longint unsigned ym;
        longint unsigned t;
        longint r;
        x = -longint'(65536) + longint'(udiv(k * 64'd131072, SHAPE_N));
        m = (x < 0) ? longint'(-x) : longint'(x);
        ym = udiv(m * 64'd18 + 64'd5, 64'd10);
        t = tanh_q16(ym);
        r = longint'(((t << (SMP_W - 1)) + 64'd32768) >> 16);
        return (x < 0) ? -r : r;
    endfunction

    function automatic t_shape_rom build_shape();
        t_shape_rom rom;
        for (int i = 0; i <= SHAPE_N; i++) begin
            rom[i] = SMP_W'(shape_val(longint'(i)));
        end
        return rom;
    endfunction

    localparam t_sine_rom  SINE_ROM  = build_sine();
    localparam t_shape_rom SHAPE_ROM = build_shape();

endpackage

// File: hw/rtl/smfd_mul.sv
// Shared signed multiplier with registered product.
module smfd_mul (
    input  logic                                 i_clk,
    input  logic signed [smfd_pkg::MUL_W-1:0]    i_a,
    input  logic signed [smfd_pkg::MUL_W-1:0]    i_b,
    output logic signed [2*smfd_pkg::MUL_W-1:0]  o_p
);

    logic signed [2*smfd_pkg::MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// File: hw/rtl/stereo_modulated_feedback_delay_top.sv
// Top level: stereo LFO-modulated fractional delay with feedback and tanh shaper.
//
//  channel  direction  signals                              item
//  s_axis   in         tvalid tready tdata[31:0] tlast      one stereo frame
//  m_axis   out        tvalid tready tdata[31:0] tlast      one mixed frame
//  cfg      in         i_cfg_valid o_cfg_ready index data   one register write
//
// A frame is processed state by state from acceptance to output load: one shared
// 33x33 multiplier is stepped through 14 products and the delay memory has one port.
// After reset a clearing pass writes all 131072 memory words with s_axis_tready
// low. The finished frame sits in the output register, the next frame is taken
// meanwhile; the load stalls only while it is still full.
module stereo_modulated_feedback_delay_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // left_in, right_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // left_out, right_out
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = smfd_pkg::ADDR_W;
    localparam int MW = smfd_pkg::MUL_W;

    typedef enum logic [18:0] {
        S_CLEAR = 19'b0000000000000000001,
        S_IDLE  = 19'b0000000000000000010,
        S_SIN   = 19'b0000000000000000100,
        S_SCL   = 19'b0000000000000001000,
        S_DIV   = 19'b0000000000000010000,
        S_DLY   = 19'b0000000000000100000,
        S_FB0   = 19'b0000000000001000000,
        S_FB1   = 19'b0000000000010000000,
        S_WR    = 19'b0000000000100000000,
        S_RD0   = 19'b0000000001000000000,
        S_RD1   = 19'b0000000010000000000,
        S_IP    = 19'b0000000100000000000,
        S_Y     = 19'b0000001000000000000,
        S_SHB   = 19'b0000010000000000000,
        S_SHM   = 19'b0000100000000000000,
        S_SH    = 19'b0001000000000000000,
        S_OG    = 19'b0010000000000000000,
        S_D     = 19'b0100000000000000000,
        S_MIX   = 19'b1000000000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_done;

    logic [16:0] r_wet, r_oct, r_base;
    logic [15:0] r_fbg;
    logic [31:0] r_step;

    logic [AW-1:0]      r_clr, r_wp, r_i0;
    logic [31:0]        r_phase;
    logic signed [15:0] r_fb_l, r_fb_r, r_dry_l, r_dry_r, r_wl;
    logic               r_last, r_ch;
    logic signed [17:0] r_sin;
    logic [8:0]         r_w;
    logic [31:0]        r_rd, r_y0;
    logic [9:0]         r_idx;
    logic [5:0]         r_sfr;
    logic signed [15:0] r_sh_q, r_a;
    logic signed [16:0] r_shim;
    logic [39:0]        r_acc;
    logic signed [15:0] r_res_l, r_res_r;
    logic [31:0]        r_odata;
    logic               r_olast, r_ovalid;

    logic [31:0] r_mem [smfd_pkg::DEPTH];

    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] mul_p;

    function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
        logic signed [15:0] r;
        if (v > 50'sd32767) r = 16'sh7FFF;
        else if (v < -50'sd32768) r = 16'sh8000;
        else r = v[15:0];
        return r;
    endfunction

    logic [15:0] fbg_c;
    logic [16:0] og_c, wg_c;
    logic signed [18:0] sin_sum;
    logic [19:0] m2;
    logic [25:0] q, dfx;
    logic        carry;
    logic [39:0] fsum, msum;
    logic signed [15:0] wr_val, wr_dry, y0, y1, dry_c, sh16, mix;
    logic [16:0] yv, shv;
    logic [15:0] u;
    logic [10:0] sh_addr;
    logic [AW-1:0] mem_addr;
    logic        mem_we, mem_re, load_out;

    assign fbg_c = (r_fbg > 16'(smfd_pkg::FB_LIMIT)) ? 16'(smfd_pkg::FB_LIMIT) : r_fbg;
    assign og_c  = (r_oct > 17'(smfd_pkg::UNITY)) ? 17'(smfd_pkg::UNITY) : r_oct;
    assign wg_c  = (r_wet > 17'(smfd_pkg::UNITY)) ? 17'(smfd_pkg::UNITY) : r_wet;

    assign sin_sum = 19'sd65536 + 19'(r_sin);
    assign m2      = 20'd786432 + {3'b0, sin_sum[17:1]};
    assign q       = mul_p[60:35];
    assign dfx     = (q < 26'd256) ? 26'd256 : q;
    assign carry   = |dfx[7:0];

    assign fsum   = mul_p[39:0] + 40'd32768;
    assign wr_dry = (r_state == S_WR) ? r_dry_r : r_dry_l;
    assign wr_val = sat16(50'(wr_dry) + 50'($signed(fsum[39:16])));

    assign y0    = r_ch ? r_y0[31:16] : r_y0[15:0];
    assign y1    = r_ch ? r_rd[31:16] : r_rd[15:0];
    assign dry_c = r_ch ? r_dry_r : r_dry_l;
    assign yv    = 17'(y0) + mul_p[24:8];
    assign u     = {~yv[15], yv[14:0]};
    assign shv   = 17'(r_a) + mul_p[22:6];
    assign sh16  = shv[15:0];
    assign msum  = r_acc + mul_p[39:0] + 40'd32768;
    assign mix   = sat16(50'($signed(msum[39:16])));
    assign load_out = r_done && (!r_ovalid || m_axis_tready);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SCL: begin
                mul_a = {16'b0, r_base};
                mul_b = {13'b0, m2};
            end
            S_DIV: begin
                mul_a = {3'b0, mul_p[36:7]};
                mul_b = {2'b0, smfd_pkg::RECIP_25};
            end
            S_FB0: begin
                mul_a = MW'(r_fb_l);
                mul_b = {17'b0, fbg_c};
            end
            S_FB1: begin
                mul_a = MW'(r_fb_r);
                mul_b = {17'b0, fbg_c};
            end
            S_IP: begin
                mul_a = MW'(y1) - MW'(y0);
                mul_b = {24'b0, r_w};
            end
            S_SHM: begin
                mul_a = MW'(r_sh_q) - MW'(r_a);
                mul_b = {27'b0, r_sfr};
            end
            S_SH: begin
                mul_a = MW'(sh16);
                mul_b = {16'b0, og_c};
            end
            S_OG: begin
                mul_a = MW'(dry_c);
                mul_b = {16'b0, 17'(smfd_pkg::UNITY) - wg_c};
            end
            S_D: begin
                mul_a = MW'(r_shim);
                mul_b = {16'b0, wg_c};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    smfd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (&r_clr) n_state = S_IDLE;
            S_IDLE:  if (s_axis_tvalid) n_state = S_SIN;
            S_SIN:   n_state = S_SCL;
            S_SCL:   n_state = S_DIV;
            S_DIV:   n_state = S_DLY;
            S_DLY:   n_state = S_FB0;
            S_FB0:   n_state = S_FB1;
            S_FB1:   n_state = S_WR;
            S_WR:    n_state = S_RD0;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_IP;
            S_IP:    n_state = S_Y;
            S_Y:     n_state = S_SHB;
            S_SHB:   n_state = S_SHM;
            S_SHM:   n_state = S_SH;
            S_SH:    n_state = S_OG;
            S_OG:    n_state = S_D;
            S_D:     n_state = S_MIX;
            S_MIX:   n_state = r_ch ? S_IDLE : S_IP;
            default: n_state = S_CLEAR;
        endcase
        if (r_state == S_IDLE && r_done && !load_out) n_state = S_IDLE;
    end

    assign s_axis_tready = (r_state == S_IDLE) && (!r_done || load_out);

    always_comb begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = r_i0;
        priority case (1'b1)
            r_state == S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
            end
            r_state == S_WR: begin
                mem_we   = 1'b1;
                mem_addr = r_wp;
            end
            r_state == S_RD0: mem_re = 1'b1;
            r_state == S_RD1: begin
                mem_re   = 1'b1;
                mem_addr = r_i0 + AW'(1);
            end
            default: mem_addr = r_i0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= (r_state == S_CLEAR) ? 32'd0 : {wr_val, r_wl};
        if (mem_re) r_rd <= r_mem[mem_addr];
    end

    assign sh_addr = (r_state == S_SHB) ? {1'b0, r_idx} + 11'd1 : {1'b0, u[15:6]};

    always_ff @(posedge i_clk) begin
        r_sin  <= smfd_pkg::SINE_ROM[r_phase[31:22]];
        r_sh_q <= smfd_pkg::SHAPE_ROM[sh_addr];
    end

    // datapath captures
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_dry_l <= s_axis_tdata[15:0];
            r_dry_r <= s_axis_tdata[31:16];
            r_last  <= s_axis_tlast;
        end
        if (r_state == S_DLY) begin
            r_i0 <= r_wp - dfx[8+AW-1:8] - AW'(carry);
            r_w  <= carry ? 9'd256 - {1'b0, dfx[7:0]} : 9'd0;
        end
        if (r_state == S_FB1) r_wl <= wr_val;
        if (r_state == S_RD1) r_y0 <= r_rd;
        if (r_state == S_Y) begin
            r_idx <= u[15:6];
            r_sfr <= u[5:0];
        end
        if (r_state == S_SHB) r_a <= r_sh_q;
        if (r_state == S_OG) r_shim <= fsum[32:16];
        if (r_state == S_D) r_acc <= mul_p[39:0];
        if (r_state == S_MIX && !r_ch) r_res_l <= mix;
        if (r_state == S_MIX && r_ch) r_res_r <= mix;
        if (load_out) begin
            r_odata <= {r_res_r, r_res_l};
            r_olast <= r_last;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_wp     <= '0;
            r_phase  <= '0;
            r_fb_l   <= '0;
            r_fb_r   <= '0;
            r_ch     <= 1'b0;
            r_done   <= 1'b0;
            r_ovalid <= 1'b0;
            r_wet    <= 17'd32768;
            r_fbg    <= 16'd32768;
            r_oct    <= 17'd32768;
            r_base   <= 17'd22050;
            r_step   <= 32'd24347;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + AW'(1);
            if (s_axis_tvalid && s_axis_tready) r_phase <= r_phase + r_step;
            if (r_state == S_SH) begin
                if (r_ch) r_fb_r <= sh16;
                else r_fb_l <= sh16;
            end
            if (r_state == S_MIX) begin
                r_ch <= ~r_ch;
                if (r_ch) begin
                    r_done <= 1'b1;
                    r_wp   <= r_wp + AW'(1);
                end
            end
            if (load_out) r_done <= 1'b0;
            if (load_out) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    smfd_pkg::CFG_WET:  r_wet  <= i_cfg_data[16:0];
                    smfd_pkg::CFG_FB:   r_fbg  <= i_cfg_data[15:0];
                    smfd_pkg::CFG_OCT:  r_oct  <= i_cfg_data[16:0];
                    smfd_pkg::CFG_BASE: r_base <= i_cfg_data[16:0];
                    smfd_pkg::CFG_STEP: r_step <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

endmodule

// File: dv/stereo_modulated_feedback_delay_top_tb.sv
// Testbench: random and directed stereo frames checked against a local predictor.
module stereo_modulated_feedback_delay_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIMIT     = 1_500_000;
    localparam logic [2:0]  CFG_SPARE = 3'd5;   // unmapped index, must be ignored

    typedef struct packed {
        logic signed [smfd_pkg::SMP_W-1:0] left;
        logic signed [smfd_pkg::SMP_W-1:0] right;
        logic                              last;
    } t_frame;

    class delay_scoreboard;
        int          errors;
        t_frame      expected_q[$];
        longint      sine_tab[smfd_pkg::SINE_N];
        longint      shaper_tab[smfd_pkg::SHAPE_N+1];
        int          left_mem[smfd_pkg::DEPTH];
        int          right_mem[smfd_pkg::DEPTH];
        int unsigned wr_pos;
        logic [31:0] phase;
        longint      left_fb, right_fb;
        longint      wet, fb_gain, oct, base;
        logic [31:0] step;

        function new();
            longint unsigned p, q, t, t2, in_t, mid, s, m, ym, y4, y6, n, d, th;
            longint x, r;
            for (int k = 0; k < smfd_pkg::SINE_N; k++) begin
                p = longint'(k) << 22;
                q = (p >> 30) & 3;
                t = (p & 64'h3FFF_FFFF) >> 14;
                if (q[0]) t = 65536 - t;
                t2 = (t * t) >> 16;
                in_t = 42184 - ((t2 * 4776) >> 16);
                mid = 102944 - ((t2 * in_t) >> 16);
                s = (t * mid) >> 16;
                if (s > 65536) s = 65536;
                sine_tab[k] = q[1] ? -longint'(s) : longint'(s);
            end
            for (int k = 0; k <= smfd_pkg::SHAPE_N; k++) begin
                x = -65536 + longint'(k) * 128;
                m = (x < 0) ? -x : x;
                ym = (m * 18 + 5) / 10;
                t2 = (ym * ym) >> 16;
                y4 = (t2 * t2) >> 16;
                y6 = (y4 * t2) >> 16;
                n = (64'd135135 << 16) + 17325 * t2 + 378 * y4 + y6;
                d = (64'd135135 << 16) + 62370 * t2 + 3150 * y4 + 28 * y6;
                th = (n * ym + d / 2) / d;
                r = longint'(((th << (smfd_pkg::SMP_W - 1)) + 32768) >> 16);
                shaper_tab[k] = (x < 0) ? -r : r;
            end
            for (int i = 0; i < smfd_pkg::DEPTH; i++) begin
                left_mem[i] = 0;
                right_mem[i] = 0;
            end
            wr_pos = 0;
            phase = 0;
            left_fb = 0;
            right_fb = 0;
            wet = 32768;
            fb_gain = 32768;
            oct = 32768;
            base = 22050;
            step = 24347;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                smfd_pkg::CFG_WET:  wet = val[16:0];
                smfd_pkg::CFG_FB:   fb_gain = val[15:0];
                smfd_pkg::CFG_OCT:  oct = val[16:0];
                smfd_pkg::CFG_BASE: base = val[16:0];
                smfd_pkg::CFG_STEP: step = val;
                default: ;
            endcase
        endfunction

        function longint clip(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function longint tanh_lookup(longint y);
            longint unsigned scaled;
            longint idx, fr, a, b;
            scaled = longint'(y + 32768) * smfd_pkg::SHAPE_N;
            idx = scaled >> smfd_pkg::SMP_W;
            fr = scaled & 16'hFFFF;
            a = shaper_tab[idx];
            b = shaper_tab[idx + 1];
            return a + (((b - a) * fr) >>> smfd_pkg::SMP_W);
        endfunction

        function longint run_channel(bit is_right, longint dry, longint di, longint carry,
                                     longint w, longint fbg, longint og, longint wg);
            longint wr, y0, y1, y, sh, shim, acc;
            int unsigned i0, i1;
            wr = clip(dry + (((is_right ? right_fb : left_fb) * fbg + 32768) >>> 16));
            if (is_right) right_mem[wr_pos] = int'(wr);
            else left_mem[wr_pos] = int'(wr);
            i0 = int'((longint'(wr_pos) + 2 * smfd_pkg::DEPTH - (di % smfd_pkg::DEPTH)
                       - carry) % smfd_pkg::DEPTH);
            i1 = (i0 + 1) % smfd_pkg::DEPTH;
            y0 = is_right ? right_mem[i0] : left_mem[i0];
            y1 = is_right ? right_mem[i1] : left_mem[i1];
            y = y0 + (((y1 - y0) * w) >>> 8);
            sh = tanh_lookup(y);
            if (is_right) right_fb = sh;
            else left_fb = sh;
            shim = (sh * og + 32768) >>> 16;
            acc = dry * (smfd_pkg::UNITY - wg) + shim * wg;
            return clip((acc + 32768) >>> 16);
        endfunction

        function void note_frame(logic signed [15:0] l, logic signed [15:0] r, logic last);
            longint md, scale, dfx, di, fr, carry, w, fbg, og, wg;
            t_frame e;
            phase = phase + step;
            md = (65536 + sine_tab[phase[31:22]]) >> 1;
            scale = 96 * 65536 + 8 * md;
            dfx = ((base * scale) << 8) / 6553600;
            if (dfx < 256) dfx = 256;
            di = dfx >> 8;
            fr = dfx & 255;
            carry = (fr != 0);
            w = fr ? 256 - fr : 0;
            fbg = fb_gain > smfd_pkg::FB_LIMIT ? smfd_pkg::FB_LIMIT : fb_gain;
            og = oct > smfd_pkg::UNITY ? smfd_pkg::UNITY : oct;
            wg = wet > smfd_pkg::UNITY ? smfd_pkg::UNITY : wet;
            e.left = 16'(run_channel(0, l, di, carry, w, fbg, og, wg));
            e.right = 16'(run_channel(1, r, di, carry, w, fbg, og, wg));
            e.last = last;
            wr_pos = (wr_pos + 1) % smfd_pkg::DEPTH;
            expected_q.push_back(e);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("MISMATCH %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_frame(t_frame got);
            t_frame e;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected frame, left", got.left, 0);
                return;
            end
            e = expected_q.pop_front();
            if (got.left !== e.left) report_mismatch("left_out", got.left, e.left);
            if (got.right !== e.right) report_mismatch("right_out", got.right, e.right);
            if (got.last !== e.last) report_mismatch("block_end", got.last, e.last);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = 0;
    logic [31:0] i_cfg_data = 0;

    delay_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int hold_cycles = 0;
    int cycles = 0;

    stereo_modulated_feedback_delay_top uut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            m_axis_tready = 0;
            hold_cycles--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_frame({m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tlast});
    end

    task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task automatic send_frame(logic signed [15:0] l, logic signed [15:0] r, logic last);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid = 0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1;
        s_axis_tdata = {r, l};
        s_axis_tlast = last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_frame(l, r, last);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic set_all(logic [31:0] wet, logic [31:0] fb, logic [31:0] oct,
                           logic [31:0] base, logic [31:0] step);
        write_cfg(smfd_pkg::CFG_WET, wet);
        write_cfg(smfd_pkg::CFG_FB, fb);
        write_cfg(smfd_pkg::CFG_OCT, oct);
        write_cfg(smfd_pkg::CFG_BASE, base);
        write_cfg(smfd_pkg::CFG_STEP, step);
    endtask

    function automatic logic [31:0] pick(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                         logic [31:0] rnd);
        case ($urandom_range(3))
            0: return a;
            1: return b;
            2: return c;
            default: return rnd;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [31:0] base_sel;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;

        // clamps, shortest delay, saturation on write and output
        set_all(131071, 65535, 131071, 0, 0);
        send_frame(16'sh7FFF, 16'sh7FFF, 0);
        send_frame(16'sh8000, 16'sh8000, 1);
        send_frame(16'sh7FFF, 16'sh8000, 0);
        send_frame(16'sh8000, 16'sh7FFF, 0);
        send_frame(0, 0, 1);
        send_frame(1, -1, 0);
        send_frame(16'sh7FFF, 16'sh7FFF, 0);
        send_frame(16'sh7FFF, 16'sh7FFF, 1);
        drain();
        // longest delay, all gains zero, full-range phase step
        set_all(0, 0, 0, 131071, 32'hFFFF_FFFF);
        send_frame(16'sh5555, 16'shAAAA, 0);
        send_frame(16'shAAAA, 16'sh5555, 1);
        send_frame(16'sh8000, 16'sh7FFF, 0);
        send_frame(0, 0, 0);
        drain();
        write_cfg(CFG_SPARE, 32'hFFFF_FFFF);
        set_all(65536, 62259, 65536, 125000, 32'h4000_0000);
        send_frame(16'sh7FFF, 16'sh8000, 0);
        send_frame(16'sh1234, 16'shEDCB, 1);
        send_frame(-1, 1, 0);
        send_frame(0, 16'sh7FFF, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin send_idle = 12; recv_idle = 83; end
                1: begin send_idle = 83; recv_idle = 12; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            if ($urandom_range(3) == 0)
                base_sel = pick(0, 125000, 131071, $urandom_range(1, 131071));
            else
                base_sel = $urandom_range(1, 400);
            set_all(pick(0, 65536, 131071, $urandom_range(0, 131071)),
                    pick(0, 62259, 65535, $urandom_range(0, 65535)),
                    pick(0, 65536, 131071, $urandom_range(0, 131071)),
                    base_sel,
                    pick(0, 32'hFFFF_FFFF, $urandom_range(0, 1 << 24), $urandom));
            if (ph == 4) hold_cycles = 400;
            for (int n = 0; n < 258; n++)
                send_frame(rand_sample(), rand_sample(), ($urandom_range(7) == 0));
            drain();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/smfd_pkg.sv
hw/rtl/smfd_mul.sv
hw/rtl/stereo_modulated_feedback_delay_top.sv
dv/stereo_modulated_feedback_delay_top_tb.sv
